// File: rtl/core/bgd_pkg.sv
package bgd_pkg;

  // button order inside the sample
  localparam int NUM_BTN = 5;
  localparam int BTN_PAUSE = 0;
  localparam int BTN_UP = 1;
  localparam int BTN_DOWN = 2;
  localparam int BTN_FOUR = 3;
  localparam int BTN_FIVE = 4;

  localparam bit FIVE_BUTTONS_DEF = 1'b1;

  // hold counter width: the largest threshold is 65535 + 255 * 65535 < 2^24,
  // so a counter saturating at 2^24-1 compares the same as a 32 bit one
  localparam int TICK_W = 24;
  localparam int DEB_W = 8;
  localparam int LP_W = 16;
  localparam int RT_W = 16;
  localparam int RF_W = 8;
  localparam int CODE_W = 5;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd3;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd25;
  localparam logic [LP_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [RT_W-1:0] REPEAT_RST = 16'd100;
  localparam logic ACTIVE_LOW_RST = 1'b1;

  // gesture codes
  localparam logic [CODE_W-1:0] GC_NONE = 5'd0;
  localparam logic [CODE_W-1:0] GC_PAUSE = 5'd1;
  localparam logic [CODE_W-1:0] GC_PAUSE_LONG = 5'd2;
  localparam logic [CODE_W-1:0] GC_UP = 5'd3;
  localparam logic [CODE_W-1:0] GC_UP_LONG = 5'd4;
  localparam logic [CODE_W-1:0] GC_UP_REPEAT = 5'd5;
  localparam logic [CODE_W-1:0] GC_DOWN = 5'd6;
  localparam logic [CODE_W-1:0] GC_DOWN_LONG = 5'd7;
  localparam logic [CODE_W-1:0] GC_DOWN_REPEAT = 5'd8;
  localparam logic [CODE_W-1:0] GC_FOUR = 5'd9;
  localparam logic [CODE_W-1:0] GC_FOUR_LONG = 5'd10;
  localparam logic [CODE_W-1:0] GC_FOUR_REPEAT = 5'd11;
  localparam logic [CODE_W-1:0] GC_FIVE = 5'd12;
  localparam logic [CODE_W-1:0] GC_FIVE_LONG = 5'd13;
  localparam logic [CODE_W-1:0] GC_FIVE_REPEAT = 5'd14;
  localparam logic [CODE_W-1:0] GC_ALL_LONG = 5'd15;
  localparam logic [CODE_W-1:0] GC_UPDOWN_LONG = 5'd16;

  // what one lane reports to the merge stage
  typedef struct packed {
    logic pressed;
    logic changed;
    logic held_long;
    logic held_thr;
  } lane_status_t;

  typedef struct packed {
    logic [CODE_W-1:0] short_code;
    logic [CODE_W-1:0] long_code;
    logic [CODE_W-1:0] rpt_code;
  } btn_codes_t;

  function automatic btn_codes_t btn_codes(input logic [2:0] btn);
    btn_codes_t c;
    c = '{short_code: GC_NONE, long_code: GC_NONE, rpt_code: GC_NONE};
    case (btn)
      3'd1: c = '{short_code: GC_UP, long_code: GC_UP_LONG, rpt_code: GC_UP_REPEAT};
      3'd2: c = '{short_code: GC_DOWN, long_code: GC_DOWN_LONG, rpt_code: GC_DOWN_REPEAT};
      3'd3: c = '{short_code: GC_FOUR, long_code: GC_FOUR_LONG, rpt_code: GC_FOUR_REPEAT};
      3'd4: c = '{short_code: GC_FIVE, long_code: GC_FIVE_LONG, rpt_code: GC_FIVE_REPEAT};
      default: c = '{short_code: GC_NONE, long_code: GC_NONE, rpt_code: GC_NONE};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/bgd_lane.sv
module bgd_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_i,
  input  logic                         level_i,
  input  logic [bgd_pkg::DEB_W-1:0]    deb_i,
  input  logic [bgd_pkg::LP_W-1:0]     lp_i,
  input  logic [bgd_pkg::TICK_W-1:0]   thr_i,
  output bgd_pkg::lane_status_t        status_o
);
  import bgd_pkg::*;

  logic              state_q, state_d;
  logic              chg_q, chg_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic [TICK_W-1:0] ticks_inc;

  // lockout after a debounced change, then follow the pin
  always_comb begin
    ticks_inc = (ticks_q == {TICK_W{1'b1}}) ? ticks_q : ticks_q + TICK_W'(1);
    state_d = state_q;
    chg_d = 1'b0;
    ticks_d = ticks_inc;
    if (ticks_inc >= TICK_W'(deb_i)) begin
      chg_d = (level_i != state_q);
      state_d = level_i;
      ticks_d = chg_d ? '0 : ticks_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
      chg_q <= 1'b0;
      ticks_q <= '0;
    end else if (sample_i) begin
      state_q <= state_d;
      chg_q <= chg_d;
      ticks_q <= ticks_d;
    end
  end

  assign status_o.pressed = state_q;
  assign status_o.changed = chg_q;
  assign status_o.held_long = state_q && (ticks_q >= TICK_W'(lp_i));
  assign status_o.held_thr = state_q && (ticks_q >= thr_i);

endmodule

// File: rtl/core/bgd_merge.sv
module bgd_merge #(
  parameter bit FIVE_BUTTONS = bgd_pkg::FIVE_BUTTONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bgd_pkg::lane_status_t        lanes_i [bgd_pkg::NUM_BTN],
  input  logic [bgd_pkg::LP_W-1:0]     lp_i,
  input  logic [bgd_pkg::RT_W-1:0]     rt_i,
  output logic [bgd_pkg::TICK_W-1:0]   thr_o,
  input  logic                         dec_valid_i,
  output logic                         dec_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bgd_pkg::CODE_W-1:0]   gesture_code_o,
  output logic [bgd_pkg::NUM_BTN-1:0]  pressed_mask_o
);
  import bgd_pkg::*;

  logic               ign_all_q, ign_rel_q;
  logic [RF_W-1:0]    rf_q;
  logic               out_valid_q;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [NUM_BTN-1:0] mask_q;

  logic [NUM_BTN-1:0] pressed, held_lp, held_thr, released;
  logic               none_pressed, first, found;
  logic               clear, set_all, bump, dec_fire;
  btn_codes_t         codes;

  // threshold = long + factor * repeat, fits the hold counter width
  assign thr_o = TICK_W'(lp_i) + (TICK_W'(rf_q) * TICK_W'(rt_i));

  always_comb begin
    for (int i = 0; i < NUM_BTN; i++) begin
      pressed[i] = lanes_i[i].pressed;
      held_lp[i] = lanes_i[i].held_long;
      held_thr[i] = lanes_i[i].held_thr;
      released[i] = !lanes_i[i].pressed && lanes_i[i].changed;
    end
  end

  assign none_pressed = ~|pressed;
  assign first = (rf_q == '0);

  // fixed priority decision
  always_comb begin
    code_d = GC_NONE;
    clear = 1'b0;
    set_all = 1'b0;
    bump = 1'b0;
    found = 1'b0;
    codes = btn_codes(3'd0);
    if ((ign_rel_q || ign_all_q) && none_pressed) begin
      clear = 1'b1;
    end else if (ign_all_q) begin
      code_d = GC_NONE;
    end else if ((held_lp[BTN_PAUSE] || held_lp[BTN_UP] || held_lp[BTN_DOWN])
                 && pressed[BTN_PAUSE] && pressed[BTN_UP] && pressed[BTN_DOWN]) begin
      set_all = 1'b1;
      code_d = GC_ALL_LONG;
    end else if (FIVE_BUTTONS
                 && (held_lp[BTN_PAUSE] || held_lp[BTN_FOUR] || held_lp[BTN_FIVE])
                 && pressed[BTN_PAUSE] && pressed[BTN_FOUR] && pressed[BTN_FIVE]) begin
      set_all = 1'b1;
      code_d = GC_ALL_LONG;
    end else if ((held_lp[BTN_UP] || held_lp[BTN_DOWN])
                 && pressed[BTN_UP] && pressed[BTN_DOWN]) begin
      set_all = 1'b1;
      code_d = GC_UPDOWN_LONG;
    end else if (released[BTN_PAUSE] && !ign_rel_q) begin
      code_d = GC_PAUSE;
    end else if (held_thr[BTN_PAUSE]) begin
      // pause long only once per hold, later thresholds stay silent
      if (first) begin
        code_d = GC_PAUSE_LONG;
        bump = 1'b1;
      end
    end else begin
      for (int i = BTN_UP; i < NUM_BTN; i++) begin
        if (!found) begin
          codes = btn_codes(3'(i));
          if (released[i] && !ign_rel_q) begin
            code_d = codes.short_code;
            found = 1'b1;
          end else if (held_thr[i]) begin
            code_d = first ? codes.long_code : codes.rpt_code;
            bump = 1'b1;
            found = 1'b1;
          end
        end
      end
    end
  end

  assign dec_ready_o = !out_valid_q || out_ready_i;
  assign dec_fire = dec_valid_i && dec_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_all_q <= 1'b0;
      ign_rel_q <= 1'b0;
      rf_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (dec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (dec_fire) begin
        if (clear) begin
          ign_all_q <= 1'b0;
          ign_rel_q <= 1'b0;
          rf_q <= '0;
        end
        if (set_all) begin
          ign_all_q <= 1'b1;
        end
        if (bump) begin
          ign_rel_q <= 1'b1;
          if (rf_q != {RF_W{1'b1}}) begin
            rf_q <= rf_q + RF_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      code_q <= code_d;
      mask_q <= pressed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_code_o = code_q;
  assign pressed_mask_o = mask_q;

endmodule

// File: rtl/core/button_gesture_decoder.sv
// an accepted item is registered first in the lane state, then in the output register
// throughput: one item per cycle while the output is taken; a stalled output holds off the lanes
// the repeat factor feeds back from the decision stage into the lanes' threshold compare
// reset: async active low; buttons released, counters and latches clear,
// registers return to debounce 25, long press 1000, repeat 100, active low 1
module button_gesture_decoder #(
  parameter bit FIVE_BUTTONS = bgd_pkg::FIVE_BUTTONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // sample items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bgd_pkg::NUM_BTN-1:0]     raw_pins_i,
  // gesture items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bgd_pkg::CODE_W-1:0]      gesture_code_o,
  output logic [bgd_pkg::NUM_BTN-1:0]     pressed_mask_o
);
  import bgd_pkg::*;

  // pause, up, down always; four and five only in the five button build
  localparam int NUM_LANES = FIVE_BUTTONS ? NUM_BTN : 3;

  logic [DEB_W-1:0]  deb_q;
  logic [LP_W-1:0]   lp_q;
  logic [RT_W-1:0]   rt_q;
  logic              al_q;

  logic              in_fire;
  logic              v1_q;       // lane state holds a sample not yet decided
  logic              dec_ready;
  logic [TICK_W-1:0] thr;
  lane_status_t      lane_st [NUM_BTN];

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DEBOUNCE_RST;
      lp_q <= LONG_PRESS_RST;
      rt_q <= REPEAT_RST;
      al_q <= ACTIVE_LOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE: deb_q <= cfg_data_i[DEB_W-1:0];
        REG_LONG_PRESS: lp_q <= cfg_data_i[LP_W-1:0];
        REG_REPEAT: rt_q <= cfg_data_i[RT_W-1:0];
        REG_ACTIVE_LOW: al_q <= cfg_data_i[0];
        default: deb_q <= deb_q;
      endcase
    end
  end

  // stage one: the lanes take the sample while the previous item is decided
  assign in_ready_o = !v1_q || dec_ready;
  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_fire) begin
      v1_q <= 1'b1;
    end else if (dec_ready) begin
      v1_q <= 1'b0;
    end
  end

  // one debounce lane per button, absent buttons read as released
  for (genvar g = 0; g < NUM_BTN; g++) begin : g_lane
    if (g < NUM_LANES) begin : g_on
      bgd_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .sample_i (in_fire),
        .level_i  (raw_pins_i[g] ^ al_q),
        .deb_i    (deb_q),
        .lp_i     (lp_q),
        .thr_i    (thr),
        .status_o (lane_st[g])
      );
    end else begin : g_off
      assign lane_st[g] = '0;
    end
  end

  // stage two: priority decision, latches and output register
  bgd_merge #(
    .FIVE_BUTTONS (FIVE_BUTTONS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lanes_i        (lane_st),
    .lp_i           (lp_q),
    .rt_i           (rt_q),
    .thr_o          (thr),
    .dec_valid_i    (v1_q),
    .dec_ready_o    (dec_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .gesture_code_o (gesture_code_o),
    .pressed_mask_o (pressed_mask_o)
  );

`ifndef ASSERT_OFF
  // a stalled decision must hold off new samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !dec_ready) |-> !in_ready_o)
    else $error("sample accepted while decision stalled");

  // just after a debounced change the hold count is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_st[BTN_UP].changed |-> (!lane_st[BTN_UP].held_long || lp_q == '0))
    else $error("hold count not restarted on change");

  // no code beyond the last gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gesture_code_o <= GC_UPDOWN_LONG))
    else $error("gesture code out of range");

  // without buttons four and five their bits stay released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !FIVE_BUTTONS) |-> (pressed_mask_o[BTN_FIVE:BTN_FOUR] == '0))
    else $error("absent button reported pressed");
`endif

endmodule
